FILE: sv/yaw_pitch_camera_view_update_core_defines.svh
// ----------------------------------------------------------------------------
// Camera view update assertion macros
// Shared concurrent property wrappers for the camera core modules.
// ----------------------------------------------------------------------------
`ifndef YAW_PITCH_CAMERA_VIEW_UPDATE_CORE_DEFINES_SVH
`define YAW_PITCH_CAMERA_VIEW_UPDATE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while rst_n is low
`define YPCAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define YPCAM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define YPCAM_ASSERT_IMP(lbl, ante, cons, msg)
`define YPCAM_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/ypcam_pkg.sv
// ----------------------------------------------------------------------------
// Camera view update package
// Types, codes and fixed-point constants shared by the camera core.
// ----------------------------------------------------------------------------
`default_nettype none

package ypcam_pkg;

    localparam int ANG_W      = 25;
    localparam int VEC_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int ATAN_IDX_W = 5;
    localparam int MUL_A_W    = 17;
    localparam int MUL_B_W    = 34;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic signed [VEC_W-1:0] vec_t;

    // angles in Q9.16 degrees
    localparam angle_t ANG_89  = 25'sd5832704;
    localparam angle_t ANG_90  = 25'sd5898240;
    localparam angle_t ANG_180 = 25'sd11796480;
    localparam logic signed [31:0] WRAP_MOD = 32'sd23592960;

    localparam vec_t ONE_Q14 = 16'sd16384;

    // operation codes
    localparam logic [1:0] OP_LOOK  = 2'd0;
    localparam logic [1:0] OP_MOVE  = 2'd1;
    localparam logic [1:0] OP_PLACE = 2'd2;

    // move directions
    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Z = 3'd4;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_LOOK,
        KIND_MOVE,
        KIND_PLACE
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic               use_right;
        logic               negate;
        logic [15:0]        dt;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } req_t;

    typedef struct packed {
        logic [15:0]        speed;
        logic [15:0]        sens;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic signed [31:0] off_z;
    } cfg_t;

    // arctangent of 2^-i in Q.16 degrees
    function automatic logic [21:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        case (idx)
            5'd0:    return 22'd2949120;
            5'd1:    return 22'd1740967;
            5'd2:    return 22'd919879;
            5'd3:    return 22'd466945;
            5'd4:    return 22'd234379;
            5'd5:    return 22'd117304;
            5'd6:    return 22'd58666;
            5'd7:    return 22'd29335;
            5'd8:    return 22'd14668;
            5'd9:    return 22'd7334;
            5'd10:   return 22'd3667;
            5'd11:   return 22'd1833;
            5'd12:   return 22'd917;
            5'd13:   return 22'd458;
            5'd14:   return 22'd229;
            5'd15:   return 22'd115;
            5'd16:   return 22'd57;
            5'd17:   return 22'd29;
            5'd18:   return 22'd14;
            5'd19:   return 22'd7;
            5'd20:   return 22'd4;
            5'd21:   return 22'd2;
            5'd22:   return 22'd1;
            default: return 22'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: sv/ypcam_front.sv
// ----------------------------------------------------------------------------
// Camera request front end
// Accepts input items, decodes them into requests and queues up to two of them.
// ----------------------------------------------------------------------------
`default_nettype none

module ypcam_front import ypcam_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic signed [15:0] mouse_dx,
    input  wire logic signed [15:0] mouse_dy,
    input  wire logic [2:0]         move_dir,
    input  wire logic [15:0]        delta_time,
    input  wire logic signed [31:0] place_x,
    input  wire logic signed [31:0] place_y,
    input  wire logic signed [31:0] place_z,
    output logic                    req_valid,
    input  wire logic               req_ready,
    output req_t                    req
);

    localparam int QDEPTH = 2;
    localparam int QCW    = $clog2(QDEPTH + 1);

    req_t             q_reg [QDEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;
    req_t             cls;
    logic             push, pop;

    // decode; unknown operations and directions become no-ops
    always_comb
    begin
        cls           = '0;
        cls.kind      = KIND_NOP;
        cls.dx        = mouse_dx;
        cls.dy        = mouse_dy;
        cls.dt        = delta_time;
        cls.px        = place_x;
        cls.py        = place_y;
        cls.pz        = place_z;
        case (operation)
            OP_LOOK:  cls.kind = KIND_LOOK;
            OP_PLACE: cls.kind = KIND_PLACE;
            OP_MOVE:
            begin
                case (move_dir)
                    DIR_FWD:
                    begin
                        cls.kind = KIND_MOVE;
                    end
                    DIR_BACK:
                    begin
                        cls.kind   = KIND_MOVE;
                        cls.negate = 1'b1;
                    end
                    DIR_LEFT:
                    begin
                        cls.kind      = KIND_MOVE;
                        cls.use_right = 1'b1;
                        cls.negate    = 1'b1;
                    end
                    DIR_RIGHT:
                    begin
                        cls.kind      = KIND_MOVE;
                        cls.use_right = 1'b1;
                    end
                    default: cls.kind = KIND_NOP;
                endcase
            end
            default: cls.kind = KIND_NOP;
        endcase
    end

    assign in_ready  = (count_reg != QCW'(QDEPTH));
    assign req_valid = (count_reg != '0);
    assign req       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = req_valid && req_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

FILE: sv/ypcam_cordic.sv
// ----------------------------------------------------------------------------
// Camera sine/cosine unit
// Rotation-mode CORDIC, one iteration per cycle, Q2.14 results.
// ----------------------------------------------------------------------------
`default_nettype none

module ypcam_cordic import ypcam_pkg::*;
#(
    parameter int TRIG_STEPS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    input  wire angle_t angle,
    output logic        done,
    output vec_t        sin_q,
    output vec_t        cos_q
);

    localparam int XW = 34;
    localparam int ZW = 27;
    localparam int IW = $clog2(TRIG_STEPS);
    localparam logic signed [XW-1:0] X0     = 34'sd652032874;
    localparam logic signed [XW-1:0] RND    = 34'sd32768;
    localparam logic signed [XW-1:0] LIM_HI = 34'sd16384;
    localparam logic signed [XW-1:0] LIM_LO = -34'sd16384;

    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 neg_reg, neg_next;
    logic [IW-1:0]        it_reg, it_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;

    logic signed [XW-1:0] x_sh, y_sh, xf, yf, xr, yr;
    logic signed [ZW-1:0] at_s;

    assign x_sh = x_reg >>> it_reg;
    assign y_sh = y_reg >>> it_reg;
    assign at_s = $signed(ZW'(atan_deg(ATAN_IDX_W'(it_reg))));

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        neg_next  = neg_reg;
        it_next   = it_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next   = X0;
            y_next   = '0;
            it_next  = '0;
            run_next = 1'b1;
            neg_next = 1'b0;
            z_next   = ZW'(angle);
            // fold into -90..90, flip the signs at the end
            if (angle > ANG_90)
            begin
                z_next   = ZW'(angle) - ZW'(ANG_180);
                neg_next = 1'b1;
            end
            else if (angle < -ANG_90)
            begin
                z_next   = ZW'(angle) + ZW'(ANG_180);
                neg_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - at_s;
            end
            else
            begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + at_s;
            end
            it_next = it_reg + IW'(1);
            if (it_reg == IW'(TRIG_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        neg_reg <= neg_next;
    end

    // round half up to Q2.14 and clamp to +-1
    always_comb
    begin
        xf = neg_reg ? -x_reg : x_reg;
        yf = neg_reg ? -y_reg : y_reg;
        xr = (xf + RND) >>> 16;
        yr = (yf + RND) >>> 16;
        if (xr > LIM_HI)
        begin
            xr = LIM_HI;
        end
        else if (xr < LIM_LO)
        begin
            xr = LIM_LO;
        end
        if (yr > LIM_HI)
        begin
            yr = LIM_HI;
        end
        else if (yr < LIM_LO)
        begin
            yr = LIM_LO;
        end
    end

    assign done  = done_reg;
    assign cos_q = VEC_W'(xr);
    assign sin_q = VEC_W'(yr);

endmodule

`default_nettype wire

FILE: sv/ypcam_back.sv
// ----------------------------------------------------------------------------
// Camera request engine
// Sequences look, move, place and no-op requests and emits the three view rows.
// ----------------------------------------------------------------------------
`default_nettype none
`include "yaw_pitch_camera_view_update_core_defines.svh"

module ypcam_back import ypcam_pkg::*;
#(
    parameter int POS_WIDTH  = 32,
    parameter int TRIG_STEPS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire req_t         req,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [1:0]        row_index,
    output vec_t              row_x,
    output vec_t              row_y,
    output vec_t              row_z,
    output logic signed [31:0] row_translation,
    output logic              last_row
);

    localparam int EW  = ((POS_WIDTH > 32) ? POS_WIDTH : 32) + 1;
    localparam int SW  = EW + 1;
    localparam int ACW = EW + 18;

    localparam logic signed [SW-1:0] PMAX =
        {{(SW - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] PMIN = ~PMAX;
    localparam logic signed [ACW-1:0] TMAX = {{(ACW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACW-1:0] TMIN = ~TMAX;

    typedef logic signed [POS_WIDTH-1:0] pos_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_LOOK = 8'b0000_0010,
        ST_WRAP = 8'b0000_0100,
        ST_TRIG = 8'b0000_1000,
        ST_PROD = 8'b0001_0000,
        ST_MOVE = 8'b0010_0000,
        ST_ROW  = 8'b0100_0000,
        ST_EMIT = 8'b1000_0000
    } state_t;

    function automatic vec_t sel3(input vec_t a, input vec_t b, input vec_t c,
                                  input logic [1:0] i);
        case (i)
            2'd0:    return a;
            2'd1:    return b;
            2'd2:    return c;
            default: return '0;
        endcase
    endfunction

    function automatic pos_t sat_pos(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v;
        if (v > PMAX)
        begin
            r = PMAX;
        end
        else if (v < PMIN)
        begin
            r = PMIN;
        end
        return POS_WIDTH'(r);
    endfunction

    state_t               state_reg, state_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [1:0]           row_reg, row_next;
    req_t                 cur_reg, cur_next;
    angle_t               yaw_reg, yaw_next;
    angle_t               pitch_reg, pitch_next;
    logic signed [31:0]   wrap_reg, wrap_next;
    vec_t                 front_reg [3];
    vec_t                 front_next [3];
    vec_t                 right_reg [3];
    vec_t                 right_next [3];
    vec_t                 up_reg [3];
    vec_t                 up_next [3];
    pos_t                 pos_reg [3];
    pos_t                 pos_next [3];
    logic signed [MUL_P_W-1:0] prod_reg;
    logic [31:0]          vel_reg, vel_next;
    vec_t                 sy_reg, sy_next, cy_reg, cy_next;
    vec_t                 sp_reg, sp_next, cp_reg, cp_next;
    logic                 trig_sel_reg, trig_sel_next;
    logic                 trig_busy_reg, trig_busy_next;
    logic signed [ACW-1:0] acc_reg, acc_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           row_index_reg;
    vec_t                 row_x_reg, row_y_reg, row_z_reg;
    logic signed [31:0]   row_trans_reg;
    logic                 last_row_reg;
    logic                 out_load;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic                 trig_start, trig_done;
    angle_t               trig_angle;
    vec_t                 trig_sin, trig_cos;

    vec_t                 rv0, rv1, rv2, rv_k, mv_k;
    logic [1:0]           row_k, mv_idx, pos_idx;
    pos_t                 pos_k;
    logic signed [31:0]   off_k;
    logic signed [EW-1:0] eye_k;
    logic signed [MUL_P_W-1:0] look_d, m14, mv_d;
    logic signed [31:0]   wrap_step, wrap_mod_k, pit_sum;
    logic signed [SW-1:0] pos_sum;
    logic signed [ACW-1:0] dot, ndot, trans;

    ypcam_cordic #(
        .TRIG_STEPS (TRIG_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .angle (trig_angle),
        .done  (trig_done),
        .sin_q (trig_sin),
        .cos_q (trig_cos)
    );

    // row vectors: right, up, negated front
    always_comb
    begin
        case (row_reg)
            2'd0:
            begin
                rv0 = right_reg[0];
                rv1 = right_reg[1];
                rv2 = right_reg[2];
            end
            2'd1:
            begin
                rv0 = up_reg[0];
                rv1 = up_reg[1];
                rv2 = up_reg[2];
            end
            2'd2:
            begin
                rv0 = -front_reg[0];
                rv1 = -front_reg[1];
                rv2 = -front_reg[2];
            end
            default:
            begin
                rv0 = '0;
                rv1 = '0;
                rv2 = '0;
            end
        endcase
    end

    assign row_k  = cnt_reg[2:1];
    assign rv_k   = sel3(rv0, rv1, rv2, row_k);
    assign mv_idx = 2'(cnt_reg - 3'd2);
    assign mv_k   = cur_reg.use_right ?
                    sel3(right_reg[0], right_reg[1], right_reg[2], mv_idx) :
                    sel3(front_reg[0], front_reg[1], front_reg[2], mv_idx);

    // position and offset component: row pass walks k, move pass walks cnt-3
    assign pos_idx = (state_reg == ST_MOVE) ? 2'(cnt_reg - 3'd3) : row_k;

    always_comb
    begin
        case (pos_idx)
            2'd0:
            begin
                pos_k = pos_reg[0];
                off_k = cfg.off_x;
            end
            2'd1:
            begin
                pos_k = pos_reg[1];
                off_k = cfg.off_y;
            end
            2'd2:
            begin
                pos_k = pos_reg[2];
                off_k = cfg.off_z;
            end
            default:
            begin
                pos_k = '0;
                off_k = '0;
            end
        endcase
    end

    assign eye_k = EW'(pos_k) + EW'(off_k);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LOOK:
            begin
                mul_a = (cnt_reg == 3'd0) ? MUL_A_W'(cur_reg.dx) : MUL_A_W'(cur_reg.dy);
                mul_b = {18'b0, cfg.sens};
            end
            ST_PROD:
            begin
                mul_a = cnt_reg[0] ? MUL_A_W'(sy_reg) : MUL_A_W'(cy_reg);
                mul_b = cnt_reg[1] ? MUL_B_W'(sp_reg) : MUL_B_W'(cp_reg);
            end
            ST_MOVE:
            begin
                if (cnt_reg == 3'd0)
                begin
                    mul_a = {1'b0, cfg.speed};
                    mul_b = {18'b0, cur_reg.dt};
                end
                else
                begin
                    mul_a = MUL_A_W'(mv_k);
                    mul_b = {2'b0, vel_reg};
                end
            end
            ST_ROW:
            begin
                if (cnt_reg != 3'd6)
                begin
                    mul_a = MUL_A_W'(rv_k);
                    mul_b = cnt_reg[0] ? {18'b0, eye_k[15:0]} :
                                         MUL_B_W'($signed(eye_k[EW-1:16]));
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign look_d = (prod_reg + MUL_P_W'(8)) >>> 4;
    assign m14    = (prod_reg + MUL_P_W'(8192)) >>> 14;
    assign mv_d   = (prod_reg + MUL_P_W'(2097152)) >>> 22;

    assign wrap_mod_k = WRAP_MOD <<< (3'd5 - cnt_reg);
    assign wrap_step  = (cnt_reg == 3'd0) ?
                        ((wrap_reg < 0) ? wrap_reg + (WRAP_MOD <<< 4) : wrap_reg) :
                        ((wrap_reg >= wrap_mod_k) ? wrap_reg - wrap_mod_k : wrap_reg);
    assign pit_sum    = 32'(pitch_reg) + 32'(look_d);
    assign pos_sum    = cur_reg.negate ? SW'(pos_k) - SW'(mv_d) : SW'(pos_k) + SW'(mv_d);

    assign dot   = (acc_reg + ACW'(8192)) >>> 14;
    assign ndot  = -dot;
    assign trans = (ndot > TMAX) ? TMAX : ((ndot < TMIN) ? TMIN : ndot);

    assign trig_start = (state_reg == ST_TRIG) && !trig_busy_reg;
    assign trig_angle = trig_sel_reg ? pitch_reg : yaw_reg;
    assign req_ready  = (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg + 3'd1;
        row_next       = row_reg;
        cur_next       = cur_reg;
        yaw_next       = yaw_reg;
        pitch_next     = pitch_reg;
        wrap_next      = wrap_reg;
        front_next     = front_reg;
        right_next     = right_reg;
        up_next        = up_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        sy_next        = sy_reg;
        cy_next        = cy_reg;
        sp_next        = sp_reg;
        cp_next        = cp_reg;
        trig_sel_next  = trig_sel_reg;
        trig_busy_next = trig_busy_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 3'd0;
                row_next = 2'd0;
                if (req_valid)
                begin
                    cur_next = req;
                    case (req.kind)
                        KIND_LOOK: state_next = ST_LOOK;
                        KIND_MOVE: state_next = ST_MOVE;
                        KIND_PLACE:
                        begin
                            pos_next[0]   = sat_pos(SW'(req.px));
                            pos_next[1]   = sat_pos(SW'(req.py));
                            pos_next[2]   = sat_pos(SW'(req.pz));
                            yaw_next      = -ANG_90;
                            pitch_next    = '0;
                            front_next[0] = '0;
                            front_next[1] = '0;
                            front_next[2] = -ONE_Q14;
                            right_next[0] = ONE_Q14;
                            right_next[1] = '0;
                            right_next[2] = '0;
                            up_next[0]    = '0;
                            up_next[1]    = ONE_Q14;
                            up_next[2]    = '0;
                            state_next    = ST_ROW;
                        end
                        default: state_next = ST_ROW;
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (cnt_reg == 3'd1)
                begin
                    wrap_next = 32'(yaw_reg) + 32'(look_d) + 32'(ANG_180);
                end
                else if (cnt_reg == 3'd2)
                begin
                    if (pit_sum > 32'(ANG_89))
                    begin
                        pitch_next = ANG_89;
                    end
                    else if (pit_sum < -32'(ANG_89))
                    begin
                        pitch_next = -ANG_89;
                    end
                    else
                    begin
                        pitch_next = ANG_W'(pit_sum);
                    end
                    cnt_next   = 3'd0;
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                // fold negative, then strip 16x..1x of 360 degrees
                wrap_next = wrap_step;
                if (cnt_reg == 3'd5)
                begin
                    yaw_next       = ANG_W'(wrap_step - 32'(ANG_180));
                    trig_sel_next  = 1'b0;
                    trig_busy_next = 1'b0;
                    state_next     = ST_TRIG;
                end
            end
            ST_TRIG:
            begin
                cnt_next = 3'd0;
                if (!trig_busy_reg)
                begin
                    trig_busy_next = 1'b1;
                end
                else if (trig_done)
                begin
                    trig_busy_next = 1'b0;
                    if (!trig_sel_reg)
                    begin
                        sy_next       = trig_sin;
                        cy_next       = trig_cos;
                        trig_sel_next = 1'b1;
                    end
                    else
                    begin
                        sp_next    = trig_sin;
                        cp_next    = trig_cos;
                        state_next = ST_PROD;
                    end
                end
            end
            ST_PROD:
            begin
                case (cnt_reg)
                    3'd1: front_next[0] = VEC_W'(m14);
                    3'd2: front_next[2] = VEC_W'(m14);
                    3'd3: up_next[0]    = -VEC_W'(m14);
                    3'd4:
                    begin
                        up_next[2]    = -VEC_W'(m14);
                        up_next[1]    = cp_reg;
                        front_next[1] = sp_reg;
                        right_next[0] = -sy_reg;
                        right_next[1] = '0;
                        right_next[2] = cy_reg;
                        cnt_next      = 3'd0;
                        row_next      = 2'd0;
                        state_next    = ST_ROW;
                    end
                    default: ;
                endcase
            end
            ST_MOVE:
            begin
                if (cnt_reg == 3'd1)
                begin
                    vel_next = prod_reg[31:0];
                end
                if (cnt_reg >= 3'd3)
                begin
                    pos_next[pos_idx] = sat_pos(pos_sum);
                end
                if (cnt_reg == 3'd5)
                begin
                    cnt_next   = 3'd0;
                    row_next   = 2'd0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                // odd step consumes an integer-part product
                if (cnt_reg == 3'd0)
                begin
                    acc_next = '0;
                end
                else if (cnt_reg[0])
                begin
                    acc_next = acc_reg + (ACW'(prod_reg) <<< 16);
                end
                else
                begin
                    acc_next = acc_reg + ACW'(prod_reg);
                end
                if (cnt_reg == 3'd6)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cnt_next = 3'd0;
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    if (row_reg == 2'd2)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 2'd1;
                        state_next = ST_ROW;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            row_reg       <= '0;
            yaw_reg       <= -ANG_90;
            pitch_reg     <= '0;
            front_reg[0]  <= '0;
            front_reg[1]  <= '0;
            front_reg[2]  <= -ONE_Q14;
            right_reg[0]  <= ONE_Q14;
            right_reg[1]  <= '0;
            right_reg[2]  <= '0;
            up_reg[0]     <= '0;
            up_reg[1]     <= ONE_Q14;
            up_reg[2]     <= '0;
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            pos_reg[2]    <= '0;
            trig_sel_reg  <= 1'b0;
            trig_busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            yaw_reg       <= yaw_next;
            pitch_reg     <= pitch_next;
            front_reg     <= front_next;
            right_reg     <= right_next;
            up_reg        <= up_next;
            pos_reg       <= pos_next;
            trig_sel_reg  <= trig_sel_next;
            trig_busy_reg <= trig_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        wrap_reg <= wrap_next;
        prod_reg <= mul_p;
        vel_reg  <= vel_next;
        sy_reg   <= sy_next;
        cy_reg   <= cy_next;
        sp_reg   <= sp_next;
        cp_reg   <= cp_next;
        acc_reg  <= acc_next;
        if (out_load)
        begin
            row_index_reg <= row_reg;
            row_x_reg     <= rv0;
            row_y_reg     <= rv1;
            row_z_reg     <= rv2;
            row_trans_reg <= 32'(trans);
            last_row_reg  <= (row_reg == 2'd2);
        end
    end

    assign out_valid       = out_valid_reg;
    assign row_index       = row_index_reg;
    assign row_x           = row_x_reg;
    assign row_y           = row_y_reg;
    assign row_z           = row_z_reg;
    assign row_translation = row_trans_reg;
    assign last_row        = last_row_reg;

    `YPCAM_ASSERT_IMP(a_pitch_range, 1'b1, (pitch_reg <= ANG_89) && (pitch_reg >= -ANG_89), "pitch outside +-89 degrees")
    `YPCAM_ASSERT_IMP(a_yaw_range, 1'b1, (yaw_reg >= -ANG_180) && (yaw_reg < ANG_180), "yaw outside -180..180")
    `YPCAM_ASSERT_IMP(a_trig_done, trig_done, (state_reg == ST_TRIG) && trig_busy_reg, "trig result with no request waiting")
    `YPCAM_ASSERT_NXT(a_last_row_idle, out_load && (row_reg == 2'd2), state_reg == ST_IDLE, "engine not idle after third row")

endmodule

`default_nettype wire

FILE: sv/yaw_pitch_camera_view_update_core.sv
// ----------------------------------------------------------------------------
// Yaw/pitch camera view update core
// First-person camera pose with look, move and place requests and lookAt rows.
// ----------------------------------------------------------------------------
// Each accepted request yields three rows (right, up, negated front) of the
// view matrix, each with the saturated translation -dot(row, position + offset).
// Requests are decoded into a two-deep queue, so input keeps flowing while the
// engine works; the engine runs one request at a time on one shared 17x34
// multiplier and one CORDIC unit with one iteration per cycle. Any request
// can be held up by a wait on out_ready. Configuration writes are always taken
// and should land only while idle.
`default_nettype none

module yaw_pitch_camera_view_update_core import ypcam_pkg::*;
#(
    parameter int POS_WIDTH  = 32,
    parameter int TRIG_STEPS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire logic signed [15:0]   mouse_dx,
    input  wire logic signed [15:0]   mouse_dy,
    input  wire logic [2:0]           move_dir,
    input  wire logic [15:0]          delta_time,
    input  wire logic signed [31:0]   place_x,
    input  wire logic signed [31:0]   place_y,
    input  wire logic signed [31:0]   place_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                row_index,
    output logic signed [15:0]        row_x,
    output logic signed [15:0]        row_y,
    output logic signed [15:0]        row_z,
    output logic signed [31:0]        row_translation,
    output logic                      last_row
);

    cfg_t cfg_reg, cfg_next;
    logic req_valid, req_ready;
    req_t req;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SPEED: cfg_next.speed = cfg_data[15:0];
                REG_SENS:  cfg_next.sens  = cfg_data[15:0];
                REG_OFF_X: cfg_next.off_x = cfg_data;
                REG_OFF_Y: cfg_next.off_y = cfg_data;
                REG_OFF_Z: cfg_next.off_z = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed <= 16'd640;
            cfg_reg.sens  <= 16'd6554;
            cfg_reg.off_x <= '0;
            cfg_reg.off_y <= '0;
            cfg_reg.off_z <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ypcam_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .mouse_dx   (mouse_dx),
        .mouse_dy   (mouse_dy),
        .move_dir   (move_dir),
        .delta_time (delta_time),
        .place_x    (place_x),
        .place_y    (place_y),
        .place_z    (place_z),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req)
    );

    ypcam_back #(
        .POS_WIDTH  (POS_WIDTH),
        .TRIG_STEPS (TRIG_STEPS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .row_index       (row_index),
        .row_x           (row_x),
        .row_y           (row_y),
        .row_z           (row_z),
        .row_translation (row_translation),
        .last_row        (last_row)
    );

endmodule

`default_nettype wire

FILE: bench/tb_yaw_pitch_camera_view_update_core.sv
// ----------------------------------------------------------------------------
// Camera view update core testbench
// Drives look, move, place and unknown requests with random flow control and
// checks every lookAt row against a cycle-free camera pose predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_yaw_pitch_camera_view_update_core import ypcam_pkg::*;;

    localparam int  STEPS      = 16;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  SETTLE     = 120;
    localparam longint Q16_DEG = 65536;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;

    typedef struct {
        logic [1:0]         idx;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [31:0] trans;
        logic               last;
    } view_row_t;

    localparam longint ARCTAN_Q16 [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           operation;
    logic signed [15:0]   mouse_dx;
    logic signed [15:0]   mouse_dy;
    logic [2:0]           move_dir;
    logic [15:0]          delta_time;
    logic signed [31:0]   place_x;
    logic signed [31:0]   place_y;
    logic signed [31:0]   place_z;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           row_index;
    logic signed [15:0]   row_x;
    logic signed [15:0]   row_y;
    logic signed [15:0]   row_z;
    logic signed [31:0]   row_translation;
    logic                 last_row;

    // camera pose and settings as the predictor sees them
    logic [15:0]        speed_q8;
    logic [15:0]        sens_q16;
    logic signed [31:0] eye_off [3];
    longint             yaw_q16;
    longint             pitch_q16;
    longint             cam_pos [3];
    longint             front_v [3];
    longint             right_v [3];
    longint             up_v [3];

    view_row_t rows_due [$];
    int        mismatch_count;
    int        sender_idle_pct;
    int        receiver_stall_pct;
    int        hold_request;
    int        hold_left;
    int        quiet_cycles;

    yaw_pitch_camera_view_update_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .mouse_dx        (mouse_dx),
        .mouse_dy        (mouse_dy),
        .move_dir        (move_dir),
        .delta_time      (delta_time),
        .place_x         (place_x),
        .place_y         (place_y),
        .place_z         (place_z),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .row_index       (row_index),
        .row_x           (row_x),
        .row_y           (row_y),
        .row_z           (row_z),
        .row_translation (row_translation),
        .last_row        (last_row)
    );

    always #5 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint mul_q14(input longint a, input longint b);
        return (a * b + 8192) >>> 14;
    endfunction

    function automatic void sin_cos(input longint ang, output longint s, output longint c);
        bit     flip;
        longint x, y, z, dx, dy;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (ang > 90 * Q16_DEG) begin
            ang -= 180 * Q16_DEG;
            flip = 1'b1;
        end
        else if (ang < -90 * Q16_DEG) begin
            ang += 180 * Q16_DEG;
            flip = 1'b1;
        end
        z = ang;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN_Q16[i];
            end
            else begin
                x += dx; y -= dy; z += ARCTAN_Q16[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip((x + 32768) >>> 16, -16384, 16384);
        s = clip((y + 32768) >>> 16, -16384, 16384);
    endfunction

    function automatic void rest_pose();
        yaw_q16 = -90 * Q16_DEG;
        pitch_q16 = 0;
        front_v = '{0, 0, -16384};
        right_v = '{16384, 0, 0};
        up_v    = '{0, 16384, 0};
    endfunction

    function automatic longint sat_pos(input longint v);
        return clip(v, I32_MIN, I32_MAX);
    endfunction

    function automatic void step_pos(input longint vec [3], input longint vel,
                                     input longint sgn);
        longint d;
        for (int k = 0; k < 3; k++) begin
            d = (vec[k] * vel + (longint'(1) << 21)) >>> 22;
            cam_pos[k] = sat_pos(cam_pos[k] + sgn * d);
        end
    endfunction

    function automatic longint neg_dot(input longint r [3], input longint eye [3]);
        longint hi, lo, eh, dot;
        hi = 0;
        lo = 0;
        for (int k = 0; k < 3; k++) begin
            eh = eye[k] >>> 16;
            hi += r[k] * eh;
            lo += r[k] * (eye[k] - eh * 65536);
        end
        dot = hi * 4 + ((lo + 8192) >>> 14);
        return clip(-dot, I32_MIN, I32_MAX);
    endfunction

    // advances the pose by one request and queues the three view rows
    function automatic void predict_view_rows(input logic [1:0] op,
            input logic signed [15:0] dx, input logic signed [15:0] dy,
            input logic [2:0] dir, input logic [15:0] dt,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz);
        longint    dyaw, dpit, w, vel, sy, cy, sp, cp;
        longint    eye [3];
        longint    rv [3];
        view_row_t row;
        if (op == OP_LOOK) begin
            dyaw = (longint'(dx) * longint'(sens_q16) + 8) >>> 4;
            dpit = (longint'(dy) * longint'(sens_q16) + 8) >>> 4;
            w = (yaw_q16 + dyaw + 180 * Q16_DEG) % (360 * Q16_DEG);
            if (w < 0)
                w += 360 * Q16_DEG;
            yaw_q16 = w - 180 * Q16_DEG;
            pitch_q16 = clip(pitch_q16 + dpit, -89 * Q16_DEG, 89 * Q16_DEG);
            sin_cos(yaw_q16, sy, cy);
            sin_cos(pitch_q16, sp, cp);
            front_v = '{mul_q14(cy, cp), sp, mul_q14(sy, cp)};
            right_v = '{-sy, 0, cy};
            up_v    = '{-mul_q14(cy, sp), cp, -mul_q14(sy, sp)};
        end
        else if (op == OP_MOVE) begin
            vel = longint'(speed_q8) * longint'(dt);
            case (dir)
                DIR_FWD:   step_pos(front_v, vel, 1);
                DIR_BACK:  step_pos(front_v, vel, -1);
                DIR_LEFT:  step_pos(right_v, vel, -1);
                DIR_RIGHT: step_pos(right_v, vel, 1);
                default:   ;
            endcase
        end
        else if (op == OP_PLACE) begin
            cam_pos = '{longint'(px), longint'(py), longint'(pz)};
            rest_pose();
        end
        for (int k = 0; k < 3; k++)
            eye[k] = cam_pos[k] + longint'(eye_off[k]);
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++)
                rv[k] = (r == 0) ? right_v[k] : ((r == 1) ? up_v[k] : -front_v[k]);
            row.idx   = r[1:0];
            row.x     = rv[0][15:0];
            row.y     = rv[1][15:0];
            row.z     = rv[2][15:0];
            row.trans = neg_dot(rv, eye);
            row.last  = (r == 2);
            rows_due.push_back(row);
        end
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk) begin
        view_row_t want;
        if (rst_n && out_valid && out_ready) begin
            if (rows_due.size() == 0) begin
                report_mismatch("unexpected row, index", row_index, -1);
            end
            else begin
                want = rows_due.pop_front();
                if (row_index !== want.idx)
                    report_mismatch("row_index", row_index, want.idx);
                if (row_x !== want.x)
                    report_mismatch("row_x", row_x, want.x);
                if (row_y !== want.y)
                    report_mismatch("row_y", row_y, want.y);
                if (row_z !== want.z)
                    report_mismatch("row_z", row_z, want.z);
                if (row_translation !== want.trans)
                    report_mismatch("row_translation", row_translation, want.trans);
                if (last_row !== want.last)
                    report_mismatch("last_row", last_row, want.last);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is asked for
    always @(negedge clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            out_ready = 1'b0;
            hold_left--;
        end
        else begin
            out_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_request(input logic [1:0] op, input logic signed [15:0] dx,
            input logic signed [15:0] dy, input logic [2:0] dir, input logic [15:0] dt,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        operation  = op;
        mouse_dx   = dx;
        mouse_dy   = dy;
        move_dir   = dir;
        delta_time = dt;
        place_x    = px;
        place_y    = py;
        place_z    = pz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_view_rows(op, dx, dy, dir, dt, px, py, pz);
    endtask

    task automatic stop_requests();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_all_rows();
        stop_requests();
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SPEED: speed_q8 = data[15:0];
            REG_SENS:  sens_q16 = data[15:0];
            REG_OFF_X: eye_off[0] = data;
            REG_OFF_Y: eye_off[1] = data;
            REG_OFF_Z: eye_off[2] = data;
            default:   ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] spd, input logic [15:0] sens,
            input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz);
        wait_all_rows();
        write_reg(REG_SPEED, {16'd0, spd});
        write_reg(REG_SENS, {16'd0, sens});
        write_reg(REG_OFF_X, ox);
        write_reg(REG_OFF_Y, oy);
        write_reg(REG_OFF_Z, oz);
    endtask

    function automatic logic [31:0] rand_offset();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'(0);
            default: return 32'($signed($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_mouse();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(1600)) - 800);
    endfunction

    function automatic logic signed [31:0] rand_place();
        if ($urandom_range(3) == 0)
            return $urandom;
        return 32'($signed($urandom_range(33554432)) - 16777216);
    endfunction

    task automatic send_random_request();
        logic [1:0] op;
        logic [2:0] dir;
        int         pick;
        pick = $urandom_range(99);
        op = (pick < 40) ? OP_LOOK : ((pick < 80) ? OP_MOVE : ((pick < 93) ? OP_PLACE : 2'd3));
        dir = ($urandom_range(9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(3));
        send_request(op, rand_mouse(), rand_mouse(), dir, 16'($urandom), rand_place(),
                     rand_place(), rand_place());
    endtask

    task automatic test_directed_defaults();
        send_request(OP_LOOK, 16'sd0, 16'sd0, DIR_FWD, 16'd0, 0, 0, 0);
        send_request(OP_LOOK, 16'sh7fff, 16'sh7fff, DIR_FWD, 16'd0, 0, 0, 0);
        send_request(OP_LOOK, -16'sh8000, -16'sh8000, DIR_FWD, 16'd0, 0, 0, 0);
        for (int d = 0; d < 8; d++)
            send_request(OP_MOVE, 16'sd0, 16'sd0, 3'(d), 16'hffff, 0, 0, 0);
        send_request(OP_MOVE, 16'sd0, 16'sd0, DIR_FWD, 16'd0, 0, 0, 0);
        send_request(2'd3, 16'sh7fff, -16'sh8000, DIR_RIGHT, 16'hffff, 32'h7fffffff,
                     32'h80000000, 32'h12345678);
        send_request(OP_PLACE, 16'sd0, 16'sd0, DIR_FWD, 16'd0, 32'h7fffffff,
                     32'h80000000, 32'h0);
        send_request(OP_PLACE, 16'sd0, 16'sd0, DIR_FWD, 16'd0, 32'h80000000,
                     32'h7fffffff, 32'hffffffff);
    endtask

    task automatic test_directed_extremes();
        set_config(16'hffff, 16'hffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_request(OP_PLACE, 16'sd0, 16'sd0, DIR_FWD, 16'd0, 32'h7fff0000,
                     32'h80010000, 32'h7fffffff);
        send_request(OP_LOOK, 16'sh7fff, -16'sh8000, DIR_FWD, 16'd0, 0, 0, 0);
        send_request(OP_MOVE, 16'sd0, 16'sd0, DIR_FWD, 16'hffff, 0, 0, 0);
        send_request(OP_MOVE, 16'sd0, 16'sd0, DIR_BACK, 16'hffff, 0, 0, 0);
        send_request(OP_LOOK, -16'sh8000, 16'sh7fff, DIR_FWD, 16'd0, 0, 0, 0);
        set_config(16'd0, 16'd0, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_request(OP_LOOK, 16'sh7fff, 16'sh7fff, DIR_FWD, 16'd0, 0, 0, 0);
        send_request(OP_MOVE, 16'sd0, 16'sd0, DIR_LEFT, 16'hffff, 0, 0, 0);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
        set_config(($urandom_range(3) == 0) ? 16'hffff : 16'($urandom_range(4000)),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000)),
                   rand_offset(), rand_offset(), rand_offset());
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_random_request();
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        wait_all_rows();
        hold_request = 400;
        repeat (12) send_random_request();
        // sender holds until every row is back
        wait_all_rows();
        send_random_request();
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SPEED;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_LOOK;
        mouse_dx = '0;
        mouse_dy = '0;
        move_dir = DIR_FWD;
        delta_time = '0;
        place_x = '0;
        place_y = '0;
        place_z = '0;
        out_ready = 1'b0;
        mismatch_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        speed_q8 = 16'd640;
        sens_q16 = 16'd6554;
        eye_off = '{0, 0, 0};
        cam_pos = '{0, 0, 0};
        rest_pose();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_defaults();
        test_directed_extremes();
        test_random_phase(0, 0, 25);
        test_random_phase(62, 0, 25);
        test_random_phase(0, 62, 25);
        test_random_phase(36, 36, 25);
        test_backpressure();

        wait_all_rows();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
